// ===== sv/two_wire_display_byte_writer_core_macros.svh =====
// Assertion macros shared by the two-wire display byte writer RTL.
// Each macro expects i_clk and i_rst_n to be visible at the point of use.
`ifndef TWO_WIRE_DISPLAY_BYTE_WRITER_CORE_MACROS_SVH
`define TWO_WIRE_DISPLAY_BYTE_WRITER_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define TDWBW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TDWBW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/tdwbw_pkg.sv =====
// Package for the two-wire display byte writer: transaction payload types,
// configuration types and fixed constants. No dependencies.
`default_nettype none

package tdwbw_pkg;

    typedef struct packed {
        logic       start_req;
        logic [7:0] cmd_byte;
        logic [7:0] data_byte;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic scl;
        logic sda_level;
        logic sda_drive;
        logic busy_res;
        logic done_res;
        logic ack_missing;
    } t_out_item;

    typedef struct packed {
        logic [7:0] ticks_per_delay;
        logic [7:0] ack_poll_limit;
    } t_cfg;

    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_POLL  = 1'd1;

    localparam logic [7:0] TICKS_RESET = 8'd4;
    localparam logic [7:0] POLL_RESET  = 8'd240;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

`default_nettype wire

// ===== sv/tdwbw_seq.sv =====
// Pin-level bus sequencer of the two-wire display byte writer: one tick per
// enabled step. Depends on tdwbw_pkg and the shared assertion macro header.
`default_nettype none

`include "two_wire_display_byte_writer_core_macros.svh"

module tdwbw_seq
    import tdwbw_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_in_item  i_item,
    input  wire t_cfg      i_cfg,
    output t_out_item      o_res
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_ST_A     = 4'd1;
    localparam logic [3:0] PH_ST_B     = 4'd2;
    localparam logic [3:0] PH_ST_C     = 4'd3;
    localparam logic [3:0] PH_WB_PRE   = 4'd4;
    localparam logic [3:0] PH_BIT_SET  = 4'd5;
    localparam logic [3:0] PH_BIT_HIGH = 4'd6;
    localparam logic [3:0] PH_WB_POST  = 4'd7;
    localparam logic [3:0] PH_ACK_PRE  = 4'd8;
    localparam logic [3:0] PH_ACK_HIGH = 4'd9;
    localparam logic [3:0] PH_ACK_POLL = 4'd10;
    localparam logic [3:0] PH_ACK_POST = 4'd11;
    localparam logic [3:0] PH_SP_A     = 4'd12;
    localparam logic [3:0] PH_SP_B     = 4'd13;
    localparam logic [3:0] PH_SP_C     = 4'd14;

    logic [3:0] r_phase, n_phase;
    logic [3:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_held, n_held;
    logic       r_bsel, n_bsel;
    logic [7:0] r_delay, n_delay;
    logic [7:0] r_poll, n_poll;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       r_drv, n_drv;

    // Outcome of leaving the current phase once its delay has run out.
    logic [3:0] a_phase;
    logic [3:0] a_bit;
    logic [7:0] a_shift;
    logic       a_bsel;
    logic [7:0] a_poll;
    logic [7:0] a_delay;
    logic       a_scl, a_sda, a_drv;

    logic [7:0] delay_load;
    logic [3:0] bit_inc;
    logic [7:0] shift_next;
    logic [7:0] poll_inc;
    logic       miss;
    logic       done;

    // A zero delay register behaves as one tick per delay.
    assign delay_load = (i_cfg.ticks_per_delay == 8'd0) ? 8'd0 :
                        i_cfg.ticks_per_delay - 8'd1;
    assign bit_inc    = r_bit + 4'd1;
    assign shift_next = {r_shift[6:0], 1'b0};
    assign poll_inc   = r_poll + 8'd1;

    always_comb begin
        a_phase = PH_IDLE;
        a_bit   = r_bit;
        a_shift = r_shift;
        a_bsel  = r_bsel;
        a_poll  = r_poll;
        a_scl   = r_scl;
        a_sda   = r_sda;
        a_drv   = r_drv;
        case (r_phase)
            PH_ST_A: begin
                a_phase = PH_ST_B;
                a_scl = 1'b1; a_sda = 1'b0; a_drv = 1'b1;
            end
            PH_ST_B: begin
                a_phase = PH_ST_C;
                a_scl = 1'b0; a_drv = 1'b1;
            end
            PH_ST_C: begin
                a_phase = PH_WB_PRE;
                a_scl = 1'b0; a_drv = 1'b1;
            end
            PH_WB_PRE: begin
                a_bit   = 4'd0;
                a_phase = PH_BIT_SET;
                a_scl = 1'b0; a_sda = r_shift[7]; a_drv = 1'b1;
            end
            PH_BIT_SET: begin
                a_phase = PH_BIT_HIGH;
                a_scl = 1'b1; a_drv = 1'b1;
            end
            PH_BIT_HIGH: begin
                a_shift = shift_next;
                a_bit   = bit_inc;
                a_scl   = 1'b0;
                a_drv   = 1'b1;
                if (bit_inc >= BITS_PER_BYTE) begin
                    a_phase = PH_WB_POST;
                end else begin
                    a_phase = PH_BIT_SET;
                    a_sda   = shift_next[7];
                end
            end
            PH_WB_POST: begin
                a_phase = PH_ACK_PRE;
                a_scl = 1'b0; a_drv = 1'b1;
            end
            PH_ACK_PRE: begin
                a_phase = PH_ACK_HIGH;
                a_scl = 1'b1; a_drv = 1'b1;
            end
            PH_ACK_HIGH: begin
                a_poll  = 8'd0;
                a_phase = PH_ACK_POLL;
                a_scl = 1'b0; a_drv = 1'b0;
            end
            PH_ACK_POLL: begin
                a_phase = PH_ACK_POST;
                a_scl = 1'b0; a_drv = 1'b1;
            end
            PH_ACK_POST: begin
                a_scl = 1'b0;
                a_drv = 1'b1;
                if (!r_bsel) begin
                    a_bsel  = 1'b1;
                    a_shift = r_held;
                    a_phase = PH_WB_PRE;
                end else begin
                    a_phase = PH_SP_A;
                    a_scl = 1'b1; a_sda = 1'b0;
                end
            end
            PH_SP_A: begin
                a_phase = PH_SP_B;
                a_scl = 1'b1; a_sda = 1'b1; a_drv = 1'b1;
            end
            PH_SP_B: begin
                a_phase = PH_SP_C;
                a_scl = 1'b0; a_sda = 1'b1; a_drv = 1'b1;
            end
            default: begin
                a_phase = PH_IDLE;
            end
        endcase
    end

    // Delay of the phase being entered; the other phases keep the count.
    always_comb begin
        if (a_phase == PH_ACK_POLL) begin
            a_delay = 8'd0;
        end else if (r_phase == PH_IDLE || r_phase > PH_SP_B) begin
            a_delay = r_delay;
        end else begin
            a_delay = delay_load;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_held  = r_held;
        n_bsel  = r_bsel;
        n_delay = r_delay;
        n_poll  = r_poll;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_drv   = r_drv;
        miss    = 1'b0;
        done    = 1'b0;
        if (r_phase == PH_IDLE) begin
            if (i_item.start_req) begin
                n_shift = i_item.cmd_byte;
                n_held  = i_item.data_byte;
                n_bsel  = 1'b0;
                n_bit   = 4'd0;
                n_phase = PH_ST_A;
                n_scl   = 1'b1;
                n_sda   = 1'b1;
                n_drv   = 1'b1;
                n_delay = delay_load;
            end
        end else if (r_phase == PH_ACK_POLL) begin
            if (!i_item.sda_in || poll_inc >= i_cfg.ack_poll_limit) begin
                miss    = i_item.sda_in;
                n_phase = a_phase;
                n_bit   = a_bit;
                n_shift = a_shift;
                n_bsel  = a_bsel;
                n_delay = a_delay;
                n_scl   = a_scl;
                n_sda   = a_sda;
                n_drv   = a_drv;
            end
            if (i_item.sda_in) begin
                n_poll = poll_inc;
            end
        end else if (r_phase > PH_SP_C) begin
            n_phase = PH_IDLE;
        end else if (r_delay != 8'd0) begin
            n_delay = r_delay - 8'd1;
        end else begin
            n_phase = a_phase;
            n_bit   = a_bit;
            n_shift = a_shift;
            n_bsel  = a_bsel;
            n_poll  = a_poll;
            n_delay = a_delay;
            n_scl   = a_scl;
            n_sda   = a_sda;
            n_drv   = a_drv;
        end
        if (n_phase == PH_SP_C && n_delay == 8'd0) begin
            done    = 1'b1;
            n_phase = PH_IDLE;
        end
    end

    always_comb begin
        o_res.scl         = n_scl;
        o_res.sda_level   = n_sda;
        o_res.sda_drive   = n_drv;
        o_res.busy_res    = (n_phase != PH_IDLE) || done;
        o_res.done_res    = done;
        o_res.ack_missing = miss;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bit   <= 4'd0;
            r_shift <= 8'd0;
            r_held  <= 8'd0;
            r_bsel  <= 1'b0;
            r_delay <= 8'd0;
            r_poll  <= 8'd0;
            r_scl   <= 1'b0;
            r_sda   <= 1'b1;
            r_drv   <= 1'b1;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_held  <= n_held;
            r_bsel  <= n_bsel;
            r_delay <= n_delay;
            r_poll  <= n_poll;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_drv   <= n_drv;
        end
    end

    // The data line is released exactly while the acknowledge is polled.
    `TDWBW_ASSERT_SAME(a_poll_released, r_phase == PH_ACK_POLL, !r_drv, "line driven during poll")
    // A timeout can only come out of the poll phase.
    `TDWBW_ASSERT_SAME(a_miss_in_poll, miss, r_phase == PH_ACK_POLL, "timeout outside poll")
    // Without a request an idle sequencer stays idle.
    `TDWBW_ASSERT_NEXT(a_idle_holds, i_step && r_phase == PH_IDLE && !i_item.start_req, r_phase == PH_IDLE, "left idle without request")
    // The bit counter never passes a full byte.
    `TDWBW_ASSERT_SAME(a_bit_range, 1'b1, r_bit <= BITS_PER_BYTE, "bit index out of range")

endmodule

`default_nettype wire

// ===== sv/two_wire_display_byte_writer_core.sv =====
// Top level of the two-wire display byte writer: input register, sequencer,
// configuration registers and result register. Depends on tdwbw_pkg, tdwbw_seq.
//
// Usage: every input transaction is one tick of the bus sequencer. It carries
// start_req, the two bytes to send and the sampled data line level. Each
// accepted input transaction yields exactly one output transaction holding
// the driven clock and data line levels, the drive enable and the busy, done
// and ack_missing flags after that tick. A request is acted on only while the
// sequencer is idle; the bytes are latched on that tick.
// The accepting edge loads the input register; the sequencer then steps that
// tick into the result register as soon as the result register is free or
// being emptied, so a receiver stall can hold the tick in the input register.
// Throughput is one transaction per cycle while the receiver does not stall,
// bounded by the combinational sequencer update between those two registers.
// When the receiver stalls, the result register holds its transaction, and
// the input register keeps one more; o_in_stall then rises until the stall
// clears. Configuration writes land on the next edge and are meant for idle.
// Reset (synchronous, active low) returns the bus to clock low, data high and
// driven, empties both registers and restores the delay and poll defaults.
`default_nettype none

module two_wire_display_byte_writer_core
    import tdwbw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_cfg      r_cfg;
    t_out_item w_res;
    logic      w_step;

    // The sequencer steps whenever a held tick exists and the result register
    // is free or is being emptied this cycle.
    assign w_step      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_step;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // The payload only needs to be captured with a new transaction.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_delay <= TICKS_RESET;
            r_cfg.ack_poll_limit  <= POLL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_TICKS: r_cfg.ticks_per_delay <= i_cfg_data;
                CFG_IDX_POLL:  r_cfg.ack_poll_limit  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tdwbw_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

endmodule

`default_nettype wire

// ===== test/bus_sequence_checker.sv =====
// Checker for the two-wire display byte writer: watches both channels and the
// register port, predicts every bus tick and compares it field by field.
// Depends on tdwbw_pkg for the transaction and configuration types.
module bus_sequence_checker
    import tdwbw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int unsigned           o_fail_count,
    output int unsigned           o_pending,
    output logic                  o_bus_idle
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [4:0] {
        SEQ_IDLE, SEQ_START_A, SEQ_START_B, SEQ_START_C, SEQ_BYTE_PRE,
        SEQ_BIT_SETUP, SEQ_BIT_HIGH, SEQ_BYTE_POST, SEQ_ACK_PRE, SEQ_ACK_HIGH,
        SEQ_ACK_POLL, SEQ_ACK_POST, SEQ_STOP_A, SEQ_STOP_B, SEQ_STOP_C
    } t_seq_phase;

    typedef struct packed {
        t_seq_phase phase;
        logic [3:0] bit_count;
        logic [7:0] shifter;
        logic [7:0] held_byte;
        logic       on_second;
        logic [7:0] delay_left;
        logic [7:0] polls;
        logic       scl;
        logic       sda;
        logic       drive;
    } t_bus_state;

    t_bus_state  bus_state;
    t_cfg        settings;
    t_out_item   expected_lines[$];
    int unsigned mismatches = 0;

    // Entering a timed phase sets its line levels and counts as its first tick.
    function automatic void load_phase(inout t_bus_state s, input t_seq_phase p,
                                       input logic scl, input logic lvl,
                                       input logic drv, input t_cfg c);
        logic [7:0] span;
        span = (c.ticks_per_delay == 8'd0) ? 8'd1 : c.ticks_per_delay;
        s.phase = p;
        s.scl = scl;
        s.sda = lvl;
        s.drive = drv;
        s.delay_left = (p == SEQ_ACK_POLL) ? 8'd0 : span - 8'd1;
    endfunction

    function automatic void advance_phase(inout t_bus_state s, input t_cfg c);
        case (s.phase)
            SEQ_START_A:   load_phase(s, SEQ_START_B, 1'b1, 1'b0, 1'b1, c);
            SEQ_START_B:   load_phase(s, SEQ_START_C, 1'b0, s.sda, 1'b1, c);
            SEQ_START_C:   load_phase(s, SEQ_BYTE_PRE, 1'b0, s.sda, 1'b1, c);
            SEQ_BYTE_PRE: begin
                s.bit_count = 4'd0;
                load_phase(s, SEQ_BIT_SETUP, 1'b0, s.shifter[7], 1'b1, c);
            end
            SEQ_BIT_SETUP: load_phase(s, SEQ_BIT_HIGH, 1'b1, s.sda, 1'b1, c);
            SEQ_BIT_HIGH: begin
                s.shifter = s.shifter << 1;
                s.bit_count = s.bit_count + 4'd1;
                if (s.bit_count >= BITS_PER_BYTE) begin
                    load_phase(s, SEQ_BYTE_POST, 1'b0, s.sda, 1'b1, c);
                end else begin
                    load_phase(s, SEQ_BIT_SETUP, 1'b0, s.shifter[7], 1'b1, c);
                end
            end
            SEQ_BYTE_POST: load_phase(s, SEQ_ACK_PRE, 1'b0, s.sda, 1'b1, c);
            SEQ_ACK_PRE:   load_phase(s, SEQ_ACK_HIGH, 1'b1, s.sda, 1'b1, c);
            SEQ_ACK_HIGH: begin
                s.polls = 8'd0;
                load_phase(s, SEQ_ACK_POLL, 1'b0, s.sda, 1'b0, c);
            end
            SEQ_ACK_POLL:  load_phase(s, SEQ_ACK_POST, 1'b0, s.sda, 1'b1, c);
            SEQ_ACK_POST: begin
                if (!s.on_second) begin
                    s.on_second = 1'b1;
                    s.shifter = s.held_byte;
                    load_phase(s, SEQ_BYTE_PRE, 1'b0, s.sda, 1'b1, c);
                end else begin
                    load_phase(s, SEQ_STOP_A, 1'b1, 1'b0, 1'b1, c);
                end
            end
            SEQ_STOP_A:    load_phase(s, SEQ_STOP_B, 1'b1, 1'b1, 1'b1, c);
            SEQ_STOP_B:    load_phase(s, SEQ_STOP_C, 1'b0, 1'b1, 1'b1, c);
            default:       s.phase = SEQ_IDLE;
        endcase
    endfunction

    // One bus tick: returns the line levels and flags that the tick leaves.
    function automatic t_out_item next_bus_tick(inout t_bus_state s, input t_in_item it,
                                                input t_cfg c);
        t_out_item lines;
        logic      finished;
        logic      timed_out;
        finished = 1'b0;
        timed_out = 1'b0;
        if (s.phase == SEQ_IDLE) begin
            if (it.start_req) begin
                s.shifter = it.cmd_byte;
                s.held_byte = it.data_byte;
                s.on_second = 1'b0;
                s.bit_count = 4'd0;
                load_phase(s, SEQ_START_A, 1'b1, 1'b1, 1'b1, c);
            end
        end else if (s.phase == SEQ_ACK_POLL) begin
            if (!it.sda_in) begin
                advance_phase(s, c);
            end else begin
                s.polls = s.polls + 8'd1;
                if (s.polls >= c.ack_poll_limit) begin
                    timed_out = 1'b1;
                    advance_phase(s, c);
                end
            end
        end else if (s.delay_left != 8'd0) begin
            s.delay_left = s.delay_left - 8'd1;
        end else begin
            advance_phase(s, c);
        end
        if (s.phase == SEQ_STOP_C && s.delay_left == 8'd0) begin
            finished = 1'b1;
            s.phase = SEQ_IDLE;
        end
        lines.scl = s.scl;
        lines.sda_level = s.sda;
        lines.sda_drive = s.drive;
        lines.busy_res = (s.phase != SEQ_IDLE) || finished;
        lines.done_res = finished;
        lines.ack_missing = timed_out;
        return lines;
    endfunction

    function automatic void check_bit(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0b, actual %0b", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            bus_state = '0;
            bus_state.phase = SEQ_IDLE;
            bus_state.sda = 1'b1;
            bus_state.drive = 1'b1;
            settings.ticks_per_delay = TICKS_RESET;
            settings.ack_poll_limit = POLL_RESET;
            expected_lines.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IDX_TICKS: settings.ticks_per_delay = i_cfg_data;
                    CFG_IDX_POLL:  settings.ack_poll_limit = i_cfg_data;
                    default: ;
                endcase
            end
            // A result leaves only after its input has passed through both registers, so
            // the oldest expectation is settled before this edge's input is added.
            if (i_out_valid && !i_out_stall) begin
                if (expected_lines.size() == 0) begin
                    $error("result transaction with no input transaction waiting");
                    mismatches++;
                end else begin
                    want = expected_lines.pop_front();
                    check_bit("scl", want.scl, i_out.scl);
                    check_bit("sda_level", want.sda_level, i_out.sda_level);
                    check_bit("sda_drive", want.sda_drive, i_out.sda_drive);
                    check_bit("busy_res", want.busy_res, i_out.busy_res);
                    check_bit("done_res", want.done_res, i_out.done_res);
                    check_bit("ack_missing", want.ack_missing, i_out.ack_missing);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_lines.push_back(next_bus_tick(bus_state, i_in, settings));
            end
        end
        o_pending <= expected_lines.size();
        o_bus_idle <= (bus_state.phase == SEQ_IDLE);
        o_fail_count <= mismatches;
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the two-wire display byte writer testbench: clock, reset, stimulus,
// receiver stalls and the verdict. Depends on tdwbw_pkg, the core and
// bus_sequence_checker, which does all prediction and comparison.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tdwbw_pkg::*;

    // A long receiver hold-off that lets the block fill and stall its input.
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned PHASE_COUNT = 6;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_IDX_TICKS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int unsigned fail_count;
    int unsigned pending;
    logic        bus_idle;

    // Shared between the sender and the receiver process. The quiet flags turn
    // off idling on both sides, the hold-off request asks for one long stall.
    bit send_quiet = 1'b0;
    bit stall_quiet = 1'b0;
    bit hold_off_req = 1'b0;

    // The data line is modeled in runs, so that long high stretches can outlast
    // even the largest poll limit while most acknowledges arrive quickly.
    logic        sda_now = 1'b0;
    int unsigned sda_run_left = 0;

    // Random settings after the directed part. The fourth one carries the
    // long hold-off; the last one uses the largest delay and is never drained.
    int unsigned set_ticks[PHASE_COUNT] = '{1, 2, 1, 3, 7, 255};
    int unsigned set_polls[PHASE_COUNT] = '{1, 3, 255, 17, 128, 255};
    int unsigned set_items[PHASE_COUNT] = '{150, 150, 200, 150, 150, 200};
    int unsigned set_sda_pct[PHASE_COUNT] = '{50, 60, 80, 50, 40, 50};
    int unsigned set_quiet[PHASE_COUNT] = '{0, 100, 0, 0, 80, 0};

    two_wire_display_byte_writer_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    bus_sequence_checker u_bus_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_bus_idle   (bus_idle)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic next_sda(input int unsigned high_pct);
        int unsigned r;
        if (sda_run_left == 0) begin
            sda_now = ($urandom_range(0, 99) < high_pct);
            r = $urandom_range(0, 99);
            if (r < 80) begin
                sda_run_left = $urandom_range(1, 4);
            end else if (r < 97) begin
                sda_run_left = $urandom_range(5, 40);
            end else begin
                sda_run_left = $urandom_range(200, 300);
            end
        end
        sda_run_left--;
        return sda_now;
    endfunction

    // Offers one input transaction and returns at the edge that accepts it.
    // Valid stays high on return, so back-to-back transactions need no
    // second assignment within the same time step.
    task automatic send_tick(input t_in_item item);
        int unsigned gap;
        gap = send_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        do @(posedge clk); while (in_stall);
    endtask

    // Both registers are written one after the other, only while the block
    // holds nothing and the sequencer is idle.
    task automatic configure(input logic [7:0] ticks, input logic [7:0] polls);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_IDX_TICKS;
        cfg_data <= ticks;
        @(posedge clk);
        cfg_idx <= CFG_IDX_POLL;
        cfg_data <= polls;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Feeds ticks without requests until the predicted sequencer is idle, then
    // waits for every result. The idle flag seen at an accepting edge reflects
    // all earlier transactions, and the one just accepted cannot start a write.
    task automatic drain_to_idle(input logic sda);
        t_in_item item;
        do begin
            item.start_req = 1'b0;
            item.cmd_byte = $urandom_range(0, 255);
            item.data_byte = $urandom_range(0, 255);
            item.sda_in = sda;
            send_tick(item);
        end while (!bus_idle);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Random ticks: requests are frequent, so writes mostly run back to back,
    // and requests made while busy land as ignored noise.
    task automatic run_random(input int unsigned count, input int unsigned sda_pct,
                              input int unsigned quiet_count);
        t_in_item item;
        for (int unsigned k = 0; k < count; k++) begin
            send_quiet = (k < quiet_count);
            stall_quiet = send_quiet;
            item.start_req = ($urandom_range(0, 99) < 60);
            item.cmd_byte = $urandom_range(0, 255);
            item.data_byte = $urandom_range(0, 255);
            item.sda_in = next_sda(sda_pct);
            send_tick(item);
        end
        send_quiet = 1'b0;
        stall_quiet = 1'b0;
    endtask

    // Receiver side: random stall stretches, free stretches in quiet mode, and
    // the one long hold-off, counted here in cycles.
    initial begin : receiver
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_off_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end else begin
                out_stall <= !stall_quiet && ($urandom_range(0, 2) == 0);
                repeat (stall_quiet ? 1 : pick_gap() + 1) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        t_in_item item;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values of both registers first.
        run_random(150, 40, 40);
        drain_to_idle(1'b0);

        // Directed part at the shortest delay and poll limit. The first write
        // sends all ones then all zeros with the data line left high, so both
        // acknowledges time out; requests during it must be ignored.
        configure(8'd1, 8'd1);
        item = '{start_req: 1'b1, cmd_byte: 8'hFF, data_byte: 8'h00, sda_in: 1'b1};
        send_tick(item);
        repeat (20) begin
            item = '{start_req: 1'b1, cmd_byte: 8'h00, data_byte: 8'hFF, sda_in: 1'b1};
            send_tick(item);
        end
        drain_to_idle(1'b1);
        // The opposite bytes with both acknowledges present.
        item = '{start_req: 1'b1, cmd_byte: 8'h00, data_byte: 8'hFF, sda_in: 1'b0};
        send_tick(item);
        drain_to_idle(1'b0);

        // Zero in both registers: one tick per delay, and the first high poll
        // times out.
        configure(8'd0, 8'd0);
        item = '{start_req: 1'b1, cmd_byte: 8'h80, data_byte: 8'h7F, sda_in: 1'b1};
        send_tick(item);
        drain_to_idle(1'b1);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            configure(set_ticks[p][7:0], set_polls[p][7:0]);
            hold_off_req = (p == 3);
            run_random(set_items[p], set_sda_pct[p], set_quiet[p]);
            if (p != PHASE_COUNT - 1) begin
                drain_to_idle(1'b0);
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin : watchdog
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== two_wire_display_byte_writer_core.f =====
+incdir+sv
sv/tdwbw_pkg.sv
sv/tdwbw_seq.sv
sv/two_wire_display_byte_writer_core.sv
test/bus_sequence_checker.sv
test/tb_top.sv
